FILE: hw/rtl/r2fft_pkg.sv
// ---------------------------------------------------------------------------
// r2fft_pkg
// shared types, constants and helpers of the radix-2 fft frame engine
// ---------------------------------------------------------------------------
package r2fft_pkg;

    localparam int BIN_W      = 22;
    localparam int ENTRY_W    = 2 * BIN_W;
    localparam int SUM_W      = 26;
    localparam int Z_W        = 24;
    localparam int MAX_ADDR_W = 6;

    // sin(2*pi*m/64) for m = 0..16, unsigned q1.23
    localparam logic [23:0] SINE_ROM [0:16] = '{
        24'd0,       24'd822227,  24'd1636536, 24'd2435084, 24'd3210181,
        24'd3954362, 24'd4660461, 24'd5321677, 24'd5931642, 24'd6484482,
        24'd6974873, 24'd7398092, 24'd7750063, 24'd8027397, 24'd8227423,
        24'd8348215, 24'd8388608
    };

    localparam logic signed [SUM_W-1:0] BIN_HI = SUM_W'((1 << (BIN_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] BIN_LO = -SUM_W'(1 << (BIN_W - 1));

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_PERM,
        ST_PERM_END,
        ST_BF_ISSUE,
        ST_BF_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WT
    } state_t;

    typedef enum logic {
        CFG_LOG2_SIZE    = 1'b0,
        CFG_INVERSE_MODE = 1'b1
    } cfg_index_t;

    // one read slot of a butterfly, top or bottom operand
    typedef struct packed {
        logic                  valid;
        logic                  bot;
        logic [MAX_ADDR_W-1:0] top_addr;
        logic [MAX_ADDR_W-1:0] bot_addr;
        logic [5:0]            tw_idx;
    } bf_issue_t;

    typedef struct packed {
        logic                    en;
        logic [MAX_ADDR_W-1:0]   addr;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
    } bf_wr_t;

    function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > BIN_HI) begin
            r = BIN_HI;
        end else if (v < BIN_LO) begin
            r = BIN_LO;
        end else begin
            r = v;
        end
        return r[BIN_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/r2fft_ram.sv
// ---------------------------------------------------------------------------
// r2fft_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module r2fft_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/r2fft_bfly.sv
// ---------------------------------------------------------------------------
// r2fft_bfly
// pipelined butterfly: twiddle lookup, complex multiply, round, add/sub
// ---------------------------------------------------------------------------
module r2fft_bfly #(
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  r2fft_pkg::bf_issue_t               issue,
    input  logic [r2fft_pkg::ENTRY_W-1:0]      rdata,
    output r2fft_pkg::bf_wr_t                  wr,
    output logic                               busy
);
    import r2fft_pkg::*;

    localparam int TW_W    = TWIDDLE_BITS + 1;
    localparam int SH      = 24 - TWIDDLE_BITS;
    localparam int TW_HALF = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int PROD_W  = BIN_W + TW_W;
    localparam int RSUM_W  = PROD_W + 1;

    localparam logic signed [RSUM_W-1:0] RND = RSUM_W'(1) <<< (TWIDDLE_BITS - 2);

    function automatic logic signed [TW_W-1:0] tw_scale(input logic [23:0] mag,
                                                        input logic neg);
        logic [24:0]            r;
        logic signed [TW_W-1:0] v;
        r = ({1'b0, mag} + 25'(TW_HALF)) >> SH;
        v = TW_W'(r);
        return neg ? -v : v;
    endfunction

    // twiddle for the issuing beat
    logic [1:0]             q;
    logic [3:0]             r;
    logic [23:0]            sn, cs;
    logic signed [TW_W-1:0] wr_next, wi_next;

    always_comb begin
        q  = issue.tw_idx[5:4];
        r  = issue.tw_idx[3:0];
        sn = SINE_ROM[5'(r)];
        cs = SINE_ROM[5'd16 - {1'b0, r}];
        case (q)
            2'd0: begin
                wr_next = tw_scale(cs, 1'b0);
                wi_next = tw_scale(sn, 1'b0);
            end
            2'd1: begin
                wr_next = tw_scale(sn, 1'b1);
                wi_next = tw_scale(cs, 1'b0);
            end
            2'd2: begin
                wr_next = tw_scale(cs, 1'b1);
                wi_next = tw_scale(sn, 1'b1);
            end
            default: begin
                wr_next = tw_scale(sn, 1'b0);
                wi_next = tw_scale(cs, 1'b1);
            end
        endcase
    end

    // stage 1: read data arrives
    bf_issue_t              d1_reg;
    logic signed [TW_W-1:0] wr_reg, wi_reg;
    logic signed [BIN_W-1:0] a_re_reg, a_im_reg;
    logic signed [BIN_W-1:0] b_re, b_im;

    assign b_re = rdata[ENTRY_W-1:BIN_W];
    assign b_im = rdata[BIN_W-1:0];

    // stage 2: products
    logic                    d2_v_reg;
    logic [MAX_ADDR_W-1:0]   d2_top_reg, d2_bot_reg;
    logic signed [BIN_W-1:0] a2_re_reg, a2_im_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;

    // stage 3: rounded product
    logic                    d3_v_reg;
    logic [MAX_ADDR_W-1:0]   d3_top_reg, d3_bot_reg;
    logic signed [BIN_W-1:0] a3_re_reg, a3_im_reg;
    logic signed [Z_W-1:0]   z_re_reg, z_im_reg;
    logic signed [RSUM_W-1:0] s_re, s_im, s_re_sh, s_im_sh;

    // stage 4: bottom write
    logic                    d4_v_reg;
    logic [MAX_ADDR_W-1:0]   d4_addr_reg;
    logic signed [BIN_W-1:0] d4_re_reg, d4_im_reg;

    logic signed [BIN_W-1:0] top_re, top_im, bot_re, bot_im;

    always_comb begin
        s_re    = RSUM_W'(p_rr_reg) - RSUM_W'(p_ii_reg) + RND;
        s_im    = RSUM_W'(p_ri_reg) + RSUM_W'(p_ir_reg) + RND;
        s_re_sh = s_re >>> (TWIDDLE_BITS - 1);
        s_im_sh = s_im >>> (TWIDDLE_BITS - 1);
        top_re  = sat_bin(SUM_W'(a3_re_reg) + SUM_W'(z_re_reg));
        top_im  = sat_bin(SUM_W'(a3_im_reg) + SUM_W'(z_im_reg));
        bot_re  = sat_bin(SUM_W'(a3_re_reg) - SUM_W'(z_re_reg));
        bot_im  = sat_bin(SUM_W'(a3_im_reg) - SUM_W'(z_im_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg.valid <= 1'b0;
            d2_v_reg     <= 1'b0;
            d3_v_reg     <= 1'b0;
            d4_v_reg     <= 1'b0;
        end else begin
            d1_reg.valid <= issue.valid;
            d2_v_reg     <= d1_reg.valid && d1_reg.bot;
            d3_v_reg     <= d2_v_reg;
            d4_v_reg     <= d3_v_reg;
        end
        d1_reg.bot      <= issue.bot;
        d1_reg.top_addr <= issue.top_addr;
        d1_reg.bot_addr <= issue.bot_addr;
        d1_reg.tw_idx   <= issue.tw_idx;
        wr_reg          <= wr_next;
        wi_reg          <= wi_next;
        if (d1_reg.valid && !d1_reg.bot) begin
            a_re_reg <= b_re;
            a_im_reg <= b_im;
        end
        p_rr_reg   <= b_re * wr_reg;
        p_ii_reg   <= b_im * wi_reg;
        p_ri_reg   <= b_re * wi_reg;
        p_ir_reg   <= b_im * wr_reg;
        a2_re_reg  <= a_re_reg;
        a2_im_reg  <= a_im_reg;
        d2_top_reg <= d1_reg.top_addr;
        d2_bot_reg <= d1_reg.bot_addr;
        z_re_reg   <= s_re_sh[Z_W-1:0];
        z_im_reg   <= s_im_sh[Z_W-1:0];
        a3_re_reg  <= a2_re_reg;
        a3_im_reg  <= a2_im_reg;
        d3_top_reg <= d2_top_reg;
        d3_bot_reg <= d2_bot_reg;
        d4_addr_reg <= d3_bot_reg;
        d4_re_reg  <= bot_re;
        d4_im_reg  <= bot_im;
    end

    // top result goes out first, bottom in the cycle after
    always_comb begin
        if (d3_v_reg) begin
            wr.en   = 1'b1;
            wr.addr = d3_top_reg;
            wr.re   = top_re;
            wr.im   = top_im;
        end else begin
            wr.en   = d4_v_reg;
            wr.addr = d4_addr_reg;
            wr.re   = d4_re_reg;
            wr.im   = d4_im_reg;
        end
    end

    assign busy = d1_reg.valid || d2_v_reg || d3_v_reg || d4_v_reg;

    a_wr_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(d3_v_reg && d4_v_reg))
        else $error("top and bottom write in the same cycle");

    a_bot_follows_top: assert property (@(posedge aclk) disable iff (!aresetn)
        d3_v_reg |=> d4_v_reg)
        else $error("bottom write missing after top write");

    a_products_from_bot: assert property (@(posedge aclk) disable iff (!aresetn)
        d2_v_reg |-> $past(issue.valid, 2) && $past(issue.bot, 2))
        else $error("product stage without a bottom read");

endmodule

FILE: hw/rtl/radix2_complex_fft_top.sv
// output: each bin is read out only after the previous one is taken; a frame ends with a
//   clearing sweep of the load store; the butterfly unit takes one ram read a cycle while issuing
// reset: synchronous active-low aresetn; after reset the load store is swept clear
//   before the first sample beat is taken
// ---------------------------------------------------------------------------
// radix2_complex_fft_top
// in-place radix-2 decimation-in-time fft over a load ram and a work ram
// ---------------------------------------------------------------------------
module radix2_complex_fft_top #(
    parameter int POINTS       = 64,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [2:0]                             cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_im,
    input  logic                                   s_last_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [r2fft_pkg::BIN_W-1:0]     m_bin_re,
    output logic signed [r2fft_pkg::BIN_W-1:0]     m_bin_im,
    output logic                                   m_last_bin
);
    import r2fft_pkg::*;

    localparam int MAXL  = $clog2(POINTS + 1) - 1;
    localparam int DEPTH = 1 << MAXL;
    localparam int AW    = MAXL;

    localparam logic [2:0] MAXL3 = 3'(MAXL);

    state_t state_reg, state_next;

    logic [2:0]  lg_cfg_reg;
    logic        inv_reg;
    logic [2:0]  lg;
    logic [AW:0] n, n_m1;
    logic [AW-1:0] half_m1;

    logic [AW:0]   idx_reg, idx_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] b_reg, b_next;
    logic          ph_reg, ph_next;
    logic [2:0]    s_reg, s_next;
    logic          pw_v_reg;
    logic [AW-1:0] pw_addr_reg;

    logic signed [BIN_W-1:0] out_re_reg, out_im_reg;
    logic                    out_last_reg;

    // ram ports
    logic               a_we, b_we;
    logic [AW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
    logic [ENTRY_W-1:0] a_wdata, a_rdata, b_wdata, b_rdata;

    bf_issue_t issue;
    bf_wr_t    bf_wr;
    logic      bf_busy;

    logic          s_acc, m_acc, frame_last, clear_done, stage_done;
    logic [AW-1:0] rev, src_f, src, mask_s, b_top, b_bot;

    always_comb begin
        if (lg_cfg_reg == 3'd0) begin
            lg = 3'd1;
        end else if (lg_cfg_reg > MAXL3) begin
            lg = MAXL3;
        end else begin
            lg = lg_cfg_reg;
        end
        n       = (AW+1)'(1) << lg;
        n_m1    = n - (AW+1)'(1);
        half_m1 = n_m1[AW:1];
    end

    assign s_acc      = s_valid && s_ready;
    assign m_acc      = m_valid && m_ready;
    assign frame_last = (idx_reg == n_m1);
    assign clear_done = (idx_reg[AW-1:0] == AW'(DEPTH - 1));
    assign stage_done = (s_reg == lg - 3'd1);

    // permutation source: bit reversal, followed by index negation in inverse mode
    always_comb begin
        for (int k = 0; k < AW; k++) begin
            rev[k] = idx_reg[AW-1-k];
        end
        src_f = rev >> (3'(AW) - lg);
        src   = inv_reg ? ((~src_f + AW'(1)) & n_m1[AW-1:0]) : src_f;
    end

    // butterfly addressing: insert a zero at bit s of b
    always_comb begin
        mask_s = (AW'(1) << s_reg) - AW'(1);
        b_top  = ((b_reg & ~mask_s) << 1) | (b_reg & mask_s);
        b_bot  = b_top | (AW'(1) << s_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_done) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (s_acc && s_last_sample) state_next = ST_PERM;
            end
            ST_PERM: begin
                if (frame_last) state_next = ST_PERM_END;
            end
            ST_PERM_END: state_next = ST_BF_ISSUE;
            ST_BF_ISSUE: begin
                if (ph_reg && b_reg == half_m1) state_next = ST_BF_DRAIN;
            end
            ST_BF_DRAIN: begin
                if (!bf_busy) state_next = stage_done ? ST_EMIT_RD : ST_BF_ISSUE;
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: state_next = ST_EMIT_WT;
            ST_EMIT_WT: begin
                if (m_ready) state_next = frame_last ? ST_CLEAR : ST_EMIT_RD;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_ready = (state_reg == ST_LOAD);
        m_valid = (state_reg == ST_EMIT_WT);

        a_we    = 1'b0;
        a_waddr = cnt_reg[AW-1:0];
        a_wdata = {sat_bin(SUM_W'(s_sample_re)), sat_bin(SUM_W'(s_sample_im))};
        a_raddr = src;
        if (state_reg == ST_CLEAR) begin
            a_we    = 1'b1;
            a_waddr = idx_reg[AW-1:0];
            a_wdata = '0;
        end else if (s_acc && cnt_reg < n) begin
            a_we = 1'b1;
        end

        issue.valid    = (state_reg == ST_BF_ISSUE);
        issue.bot      = ph_reg;
        issue.top_addr = MAX_ADDR_W'(b_top);
        issue.bot_addr = MAX_ADDR_W'(b_bot);
        issue.tw_idx   = 6'(6'(b_reg & mask_s) << (3'd5 - s_reg));

        if (pw_v_reg) begin
            b_we    = 1'b1;
            b_waddr = pw_addr_reg;
            b_wdata = a_rdata;
        end else begin
            b_we    = bf_wr.en;
            b_waddr = bf_wr.addr[AW-1:0];
            b_wdata = {bf_wr.re, bf_wr.im};
        end
        if (state_reg == ST_BF_ISSUE) begin
            b_raddr = ph_reg ? b_bot : b_top;
        end else begin
            b_raddr = idx_reg[AW-1:0];
        end
    end

    // counters
    always_comb begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        b_next   = b_reg;
        ph_next  = ph_reg;
        s_next   = s_reg;
        case (state_reg)
            ST_CLEAR: begin
                idx_next = clear_done ? '0 : idx_reg + (AW+1)'(1);
                cnt_next = '0;
            end
            ST_LOAD: begin
                idx_next = '0;
                if (a_we) cnt_next = cnt_reg + (AW+1)'(1);
            end
            ST_PERM: begin
                idx_next = idx_reg + (AW+1)'(1);
            end
            ST_PERM_END: begin
                b_next  = '0;
                ph_next = 1'b0;
                s_next  = '0;
            end
            ST_BF_ISSUE: begin
                ph_next = ~ph_reg;
                if (ph_reg) b_next = b_reg + AW'(1);
            end
            ST_BF_DRAIN: begin
                b_next   = '0;
                ph_next  = 1'b0;
                idx_next = '0;
                if (!bf_busy && !stage_done) s_next = s_reg + 3'd1;
            end
            ST_EMIT_WT: begin
                if (m_ready) idx_next = frame_last ? '0 : idx_reg + (AW+1)'(1);
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // inverse scaling of the bin that is read out
    logic signed [BIN_W-1:0] rd_re, rd_im;
    logic signed [BIN_W:0]   sc_re, sc_im, rnd_add;

    always_comb begin
        rd_re   = b_rdata[ENTRY_W-1:BIN_W];
        rd_im   = b_rdata[BIN_W-1:0];
        rnd_add = (BIN_W+1)'(1) <<< (lg - 3'd1);
        sc_re   = ((BIN_W+1)'(rd_re) + rnd_add) >>> lg;
        sc_im   = ((BIN_W+1)'(rd_im) + rnd_add) >>> lg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            b_reg      <= '0;
            ph_reg     <= 1'b0;
            s_reg      <= '0;
            pw_v_reg   <= 1'b0;
            lg_cfg_reg <= 3'd6;
            inv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            b_reg     <= b_next;
            ph_reg    <= ph_next;
            s_reg     <= s_next;
            pw_v_reg  <= (state_reg == ST_PERM);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOG2_SIZE:    lg_cfg_reg <= cfg_data;
                    CFG_INVERSE_MODE: inv_reg    <= cfg_data[0];
                    default:          inv_reg    <= inv_reg;
                endcase
            end
        end
        pw_addr_reg <= idx_reg[AW-1:0];
        if (state_reg == ST_EMIT_LD) begin
            out_re_reg   <= inv_reg ? sc_re[BIN_W-1:0] : rd_re;
            out_im_reg   <= inv_reg ? sc_im[BIN_W-1:0] : rd_im;
            out_last_reg <= frame_last;
        end
    end

    assign m_bin_re   = out_re_reg;
    assign m_bin_im   = out_im_reg;
    assign m_last_bin = out_last_reg;

    r2fft_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_load_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    r2fft_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_work_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .rdata   (b_rdata),
        .wr      (bf_wr),
        .busy    (bf_busy)
    );

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and emit active together");

    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BF_ISSUE |-> s_reg < lg)
        else $error("butterfly stage beyond transform size");

    a_clear_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_last_bin) |=> state_reg == ST_CLEAR)
        else $error("no clearing sweep after last bin");

    a_perm_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        pw_v_reg |-> !bf_wr.en)
        else $error("permutation write collides with butterfly write");

endmodule
